// ----- hdl/kf4_pkg.sv -----
// Shared types, codes and saturation helper for the four-state Kalman filter core.
`timescale 1ns / 1ps
package kf4_pkg;

  localparam int N_ST = 4;

  // item commands
  localparam logic [1:0] CMD_OBSERVE = 2'd0;
  localparam logic [1:0] CMD_RESET   = 2'd1;
  localparam logic [1:0] CMD_LOAD    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] CFG_H0 = 3'd0;
  localparam logic [2:0] CFG_H1 = 3'd1;
  localparam logic [2:0] CFG_H2 = 3'd2;
  localparam logic [2:0] CFG_H3 = 3'd3;
  localparam logic [2:0] CFG_R  = 3'd4;

  localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] Q_MIN = 32'sh80000000;

  typedef enum logic [12:0] {
    PH_IDLE = 13'b0000000000001,
    PH_XP   = 13'b0000000000010,
    PH_FP   = 13'b0000000000100,
    PH_FPF  = 13'b0000000001000,
    PH_HX   = 13'b0000000010000,
    PH_PH   = 13'b0000000100000,
    PH_S    = 13'b0000001000000,
    PH_DIV  = 13'b0000010000000,
    PH_XU   = 13'b0000100000000,
    PH_A    = 13'b0001000000000,
    PH_AP   = 13'b0010000000000,
    PH_JOS  = 13'b0100000000000,
    PH_DONE = 13'b1000000000000
  } phase_t;

  // Clamp to 32 bits; top bit of the result flags saturation.
  function automatic logic [32:0] sat32(input logic signed [63:0] v);
    logic [32:0] res;
    if (v > 64'(Q_MAX)) begin
      res = {1'b1, Q_MAX};
    end else if (v < 64'(Q_MIN)) begin
      res = {1'b1, Q_MIN};
    end else begin
      res = {1'b0, v[31:0]};
    end
    return res;
  endfunction

  function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
    return {{32{v[31]}}, v};
  endfunction

endpackage

// ----- hdl/kalman_filter_four_state_core.sv -----
// Top level: four-state Kalman filter on one shared multiplier and a radix-2 divider.
// Every product goes through the shared 32x32 multiplier and is registered before it is
//   accumulated; each gain divide runs on the radix-2 divider. A non-positive innovation
//   variance ends an observe item once that variance is formed. First observe after reset,
//   reset, load and unused items go straight to the result register with no arithmetic.
// One item at a time: in_stall is high until the result is registered; a result may wait
//   while the next is taken.
// Reset: synchronous active-low; zero estimate, identity covariance, F identity, Q zero.
`timescale 1ns / 1ps
module kalman_filter_four_state_core #(
  parameter int FRAC_BITS    = 16,
  parameter int STABLE_COUNT = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_observation,
  input  logic [4:0]         in_coef_index,
  input  logic signed [31:0] in_coef_value,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [31:0] out_est_0,
  output logic signed [31:0] out_est_1,
  output logic signed [31:0] out_est_2,
  output logic signed [31:0] out_est_3,
  output logic               out_is_stable,
  output logic               out_arith_fault
);
  import kf4_pkg::*;

  localparam int NW = 32 + FRAC_BITS;
  localparam int CW = $clog2(NW + 1);
  localparam logic signed [31:0] ONE_Q = 32'(64'd1 << FRAC_BITS);

  phase_t phase_r;
  logic [1:0] i_r, j_r;
  logic [2:0] k_r;
  logic       mul_half_r;
  logic       fault_r;
  logic [2:0] cnt_r;

  logic signed [31:0] h_r [N_ST];
  logic [30:0]        r_r;
  logic signed [31:0] coef_r [2*N_ST*N_ST];
  logic signed [31:0] p_r [N_ST*N_ST];
  logic signed [31:0] x_r [N_ST];
  logic signed [31:0] nx_r [3];
  logic signed [31:0] t_r [N_ST*N_ST];
  logic signed [31:0] a_r [N_ST*N_ST];
  logic signed [31:0] ph_r [N_ST];
  logic signed [31:0] g_r [N_ST];
  logic signed [31:0] z_r, y_r, s_r, kk_r;
  logic signed [63:0] acc_r, prod_r;

  logic [NW-1:0] num_r;
  logic [31:0]   rem_r;
  logic [CW-1:0] div_cnt_r;
  logic          div_run_r;

  logic               out_valid_r, out_stable_r, out_fault_r;
  logic signed [31:0] out_est_r [N_ST];

  // operand selection for the shared multiplier
  logic signed [31:0] opa, opb;
  logic signed [63:0] init_v;
  logic               sub_v, uses_j, single;
  logic [2:0]         klast;
  logic [1:0]         kk2;
  phase_t             next_ph;

  assign kk2 = 2'(k_r - 3'd2);

  always_comb begin
    opa = x_r[k_r[1:0]];
    opb = x_r[k_r[1:0]];
    init_v = '0;
    sub_v = 1'b0;
    uses_j = 1'b0;
    single = 1'b0;
    klast = 3'd3;
    next_ph = PH_DONE;
    case (phase_r)
      PH_XP: begin
        opa = coef_r[{1'b0, i_r, k_r[1:0]}];
        opb = x_r[k_r[1:0]];
        next_ph = PH_FP;
      end
      PH_FP: begin
        opa = coef_r[{1'b0, i_r, k_r[1:0]}];
        opb = p_r[{k_r[1:0], j_r}];
        uses_j = 1'b1;
        next_ph = PH_FPF;
      end
      PH_FPF: begin
        opa = t_r[{i_r, k_r[1:0]}];
        opb = coef_r[{1'b0, j_r, k_r[1:0]}];
        init_v = sx64(coef_r[{1'b1, i_r, j_r}]);
        uses_j = 1'b1;
        next_ph = PH_HX;
      end
      PH_HX: begin
        opa = h_r[k_r[1:0]];
        opb = x_r[k_r[1:0]];
        single = 1'b1;
        next_ph = PH_PH;
      end
      PH_PH: begin
        opa = p_r[{i_r, k_r[1:0]}];
        opb = h_r[k_r[1:0]];
        next_ph = PH_S;
      end
      PH_S: begin
        opa = h_r[k_r[1:0]];
        opb = ph_r[k_r[1:0]];
        init_v = {33'd0, r_r};
        single = 1'b1;
        next_ph = PH_DIV;
      end
      PH_XU: begin
        opa = g_r[i_r];
        opb = y_r;
        init_v = sx64(x_r[i_r]);
        klast = 3'd0;
        next_ph = PH_A;
      end
      PH_A: begin
        opa = g_r[i_r];
        opb = h_r[j_r];
        init_v = (i_r == j_r) ? sx64(ONE_Q) : '0;
        sub_v = 1'b1;
        uses_j = 1'b1;
        klast = 3'd0;
        next_ph = PH_AP;
      end
      PH_AP: begin
        opa = a_r[{i_r, k_r[1:0]}];
        opb = p_r[{k_r[1:0], j_r}];
        uses_j = 1'b1;
        next_ph = PH_JOS;
      end
      PH_JOS: begin
        uses_j = 1'b1;
        klast = 3'd5;
        next_ph = PH_DONE;
        if (k_r == 3'd0) begin
          opa = g_r[i_r];
          opb = g_r[j_r];
        end else if (k_r == 3'd1) begin
          opa = kk_r;
          opb = {1'b0, r_r};
        end else begin
          opa = t_r[{i_r, kk2}];
          opb = a_r[{j_r, kk2}];
        end
      end
      default: begin
        next_ph = PH_DONE;
      end
    endcase
  end

  // accumulate path
  logic signed [63:0] psh, base, sum, mult_w;
  logic [32:0]        sum_sat, psh_sat, y_sat;
  logic               first_k, last_elem;

  assign mult_w  = opa * opb;
  assign psh     = prod_r >>> FRAC_BITS;
  assign first_k = (k_r == 3'd0) || ((phase_r == PH_JOS) && (k_r == 3'd1));
  assign base    = first_k ? init_v : acc_r;
  assign sum     = sub_v ? (base - psh) : (base + psh);
  assign sum_sat = sat32(sum);
  assign psh_sat = sat32(psh);
  assign y_sat   = sat32(sx64(z_r) - sx64(sum_sat[31:0]));
  assign last_elem = single || (uses_j ? (i_r == 2'd3 && j_r == 2'd3) : (i_r == 2'd3));

  // divider path
  logic [31:0]   rem_sh, ph_mag;
  logic          rem_ge, q_neg, q_ovf;
  logic [31:0]   q_val;

  assign rem_sh = {rem_r[30:0], num_r[NW-1]};
  assign rem_ge = rem_sh >= {1'b0, s_r[30:0]};
  assign ph_mag = ph_r[i_r][31] ? 32'(-ph_r[i_r]) : ph_r[i_r];
  assign q_neg  = ph_r[i_r][31];

  always_comb begin
    if (!q_neg) begin
      q_ovf = |num_r[NW-1:31];
      q_val = q_ovf ? Q_MAX : num_r[31:0];
    end else begin
      q_ovf = (|num_r[NW-1:32]) || (num_r[31] && (|num_r[30:0]));
      q_val = q_ovf ? Q_MIN : 32'(-num_r[31:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      i_r <= '0;
      j_r <= '0;
      k_r <= '0;
      mul_half_r <= 1'b0;
      fault_r <= 1'b0;
      cnt_r <= '0;
      div_run_r <= 1'b0;
      out_valid_r <= 1'b0;
      h_r[0] <= ONE_Q;
      h_r[1] <= '0;
      h_r[2] <= '0;
      h_r[3] <= '0;
      r_r <= 31'(ONE_Q);
      for (int n = 0; n < 2*N_ST*N_ST; n++) begin
        coef_r[n] <= (n < N_ST*N_ST && n % (N_ST+1) == 0) ? ONE_Q : '0;
      end
      for (int n = 0; n < N_ST*N_ST; n++) begin
        p_r[n] <= (n % (N_ST+1) == 0) ? ONE_Q : '0;
      end
      for (int n = 0; n < N_ST; n++) begin
        x_r[n] <= '0;
      end
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_H0: h_r[0] <= cfg_data;
          CFG_H1: h_r[1] <= cfg_data;
          CFG_H2: h_r[2] <= cfg_data;
          CFG_H3: h_r[3] <= cfg_data;
          CFG_R:  r_r <= cfg_data[30:0];
          default: ;
        endcase
      end

      // drop the result once taken, unless a new one is loaded this cycle
      if (out_valid_r && !out_stall && phase_r != PH_DONE) begin
        out_valid_r <= 1'b0;
      end

      case (phase_r)
        PH_IDLE: begin
          if (in_valid) begin
            fault_r <= 1'b0;
            i_r <= '0;
            j_r <= '0;
            k_r <= '0;
            mul_half_r <= 1'b0;
            phase_r <= PH_DONE;
            case (in_cmd)
              CMD_OBSERVE: begin
                z_r <= in_observation;
                if (cnt_r == 3'd0) begin
                  cnt_r <= 3'd1;
                  x_r[0] <= in_observation;
                end else begin
                  if (cnt_r != 3'd7) begin
                    cnt_r <= cnt_r + 3'd1;
                  end
                  phase_r <= PH_XP;
                end
              end
              CMD_RESET: begin
                cnt_r <= '0;
                for (int n = 0; n < N_ST; n++) begin
                  x_r[n] <= '0;
                end
                for (int n = 0; n < N_ST*N_ST; n++) begin
                  p_r[n] <= (n % (N_ST+1) == 0) ? ONE_Q : '0;
                end
              end
              CMD_LOAD: begin
                coef_r[in_coef_index] <= in_coef_value;
              end
              default: ;
            endcase
          end
        end

        PH_DONE: begin
          // hold until the output register is free
          if (!out_valid_r || !out_stall) begin
            out_valid_r <= 1'b1;
            out_stable_r <= (cnt_r >= 3'(STABLE_COUNT));
            out_fault_r <= fault_r;
            for (int n = 0; n < N_ST; n++) begin
              out_est_r[n] <= x_r[n];
            end
            phase_r <= PH_IDLE;
          end
        end

        PH_DIV: begin
          if (!div_run_r) begin
            num_r <= {ph_mag, {FRAC_BITS{1'b0}}};
            rem_r <= '0;
            div_cnt_r <= '0;
            div_run_r <= 1'b1;
          end else if (div_cnt_r != CW'(NW)) begin
            rem_r <= rem_ge ? (rem_sh - {1'b0, s_r[30:0]}) : rem_sh;
            num_r <= {num_r[NW-2:0], rem_ge};
            div_cnt_r <= div_cnt_r + CW'(1);
          end else begin
            g_r[i_r] <= q_val;
            if (q_ovf) begin
              fault_r <= 1'b1;
            end
            div_run_r <= 1'b0;
            i_r <= i_r + 2'd1;
            if (i_r == 2'd3) begin
              phase_r <= PH_XU;
            end
          end
        end

        default: begin
          if (!mul_half_r) begin
            prod_r <= mult_w;
            mul_half_r <= 1'b1;
          end else begin
            mul_half_r <= 1'b0;
            if (phase_r == PH_JOS && k_r == 3'd0) begin
              kk_r <= psh_sat[31:0];
              if (psh_sat[32]) begin
                fault_r <= 1'b1;
              end
              k_r <= k_r + 3'd1;
            end else if (k_r != klast) begin
              acc_r <= sum;
              k_r <= k_r + 3'd1;
            end else begin
              k_r <= '0;
              if (sum_sat[32]) begin
                fault_r <= 1'b1;
              end
              case (phase_r)
                PH_XP: begin
                  if (i_r == 2'd3) begin
                    x_r[0] <= nx_r[0];
                    x_r[1] <= nx_r[1];
                    x_r[2] <= nx_r[2];
                    x_r[3] <= sum_sat[31:0];
                  end else begin
                    nx_r[i_r] <= sum_sat[31:0];
                  end
                end
                PH_FP, PH_AP: t_r[{i_r, j_r}] <= sum_sat[31:0];
                PH_FPF, PH_JOS: p_r[{i_r, j_r}] <= sum_sat[31:0];
                PH_HX: begin
                  y_r <= y_sat[31:0];
                  if (y_sat[32]) begin
                    fault_r <= 1'b1;
                  end
                end
                PH_PH: ph_r[i_r] <= sum_sat[31:0];
                PH_S: s_r <= sum_sat[31:0];
                PH_XU: x_r[i_r] <= sum_sat[31:0];
                PH_A: a_r[{i_r, j_r}] <= sum_sat[31:0];
                default: ;
              endcase
              if (last_elem) begin
                i_r <= '0;
                j_r <= '0;
                phase_r <= next_ph;
                // innovation variance not positive: keep the prediction
                if (phase_r == PH_S && $signed(sum_sat[31:0]) <= 0) begin
                  fault_r <= 1'b1;
                  phase_r <= PH_DONE;
                end
              end else if (uses_j) begin
                j_r <= j_r + 2'd1;
                if (j_r == 2'd3) begin
                  i_r <= i_r + 2'd1;
                end
              end else begin
                i_r <= i_r + 2'd1;
              end
            end
          end
        end
      endcase
    end
  end

  assign in_stall        = (phase_r != PH_IDLE);
  assign out_valid       = out_valid_r;
  assign out_est_0       = out_est_r[0];
  assign out_est_1       = out_est_r[1];
  assign out_est_2       = out_est_r[2];
  assign out_est_3       = out_est_r[3];
  assign out_is_stable   = out_stable_r;
  assign out_arith_fault = out_fault_r;

  a_div_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_DIV) |-> (s_r > 0))
    else $error("gain divide entered with non-positive innovation variance");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    div_run_r |-> (rem_r < {1'b0, s_r[30:0]}))
    else $error("divider remainder not below divisor");

  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(phase_r == PH_DONE))
    else $error("result presented without a finished transaction");

endmodule
